### hdl/stqbf_pkg.sv
package stqbf_pkg;

  // Field widths of one task beat
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned CPX_W   = 8;
  localparam int unsigned HRS_W   = 16;
  localparam int unsigned WORD_W  = PRI_W + CPX_W + HRS_W;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned BUD_W   = 21;  // DAYS_W plus room for the factor 24
  localparam int unsigned OUT_CNT_W = 7;

  localparam int unsigned HOURS_PER_DAY = 24;

  // Input action codes
  localparam logic ACT_INSERT   = 1'b0;
  localparam logic ACT_EVALUATE = 1'b1;

  typedef logic [WORD_W-1:0] task_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_READ,
    S_INS_STEP,
    S_PUT_FRONT,
    S_EVAL_READ,
    S_EVAL_STEP,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_INS_STEP,
    OP_PUT_FRONT,
    OP_EVAL_STEP,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    logic greater;     // stored key sorts after the new key
    logic idx_zero;    // walk index at the front of the list
    logic over;        // running sum went past the budget
    logic last;        // walk index is the last stored entry
    logic count_zero;
    logic count_full;
  } dp_status_t;

  // Sort key: priority ascending, complexity descending, hours ascending
  function automatic task_word_t sort_key(input task_word_t w);
    sort_key = {w[WORD_W-1 -: PRI_W], ~w[HRS_W +: CPX_W], w[HRS_W-1:0]};
  endfunction

endpackage

### hdl/stqbf_dp.sv
module stqbf_dp #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  stqbf_pkg::dp_op_t                 op,
  input  logic                              action,
  input  logic [stqbf_pkg::PRI_W-1:0]       task_priority,
  input  logic [stqbf_pkg::CPX_W-1:0]       task_complexity,
  input  logic [stqbf_pkg::HRS_W-1:0]       task_hours,
  input  logic                              cfg_wr_en,
  input  logic [stqbf_pkg::DAYS_W-1:0]      cfg_wr_data,
  output stqbf_pkg::dp_status_t             status,
  output logic [stqbf_pkg::OUT_CNT_W-1:0]   fit_count,
  output logic                              queue_full,
  output logic [stqbf_pkg::OUT_CNT_W-1:0]   stored_count
);

  localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = stqbf_pkg::HRS_W + CW;
  localparam int unsigned CMP_W = (SUM_W > stqbf_pkg::BUD_W) ? SUM_W : stqbf_pkg::BUD_W;

  stqbf_pkg::task_word_t mem [QUEUE_DEPTH];
  stqbf_pkg::task_word_t rd_data;
  stqbf_pkg::task_word_t word;
  stqbf_pkg::task_word_t wr_data;

  logic [AW-1:0]                  idx;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;
  logic                           rd_en;
  logic                           wr_en;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  fit;
  logic [CW-1:0]                  idx_inc;
  logic [SUM_W-1:0]               sum;
  logic [SUM_W-1:0]               sum_next;
  logic [stqbf_pkg::BUD_W-1:0]    budget_hours;
  logic                           full_flag;

  assign idx_inc  = CW'(idx) + CW'(1);
  assign sum_next = sum + SUM_W'(rd_data[stqbf_pkg::HRS_W-1:0]);

  assign status.greater    = stqbf_pkg::sort_key(rd_data) > stqbf_pkg::sort_key(word);
  assign status.idx_zero   = (idx == '0);
  assign status.over       = CMP_W'(sum_next) > CMP_W'(budget_hours);
  assign status.last       = (idx_inc == count);
  assign status.count_zero = (count == '0);
  assign status.count_full = (count == CW'(QUEUE_DEPTH));

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx;
    wr_en   = 1'b0;
    wr_addr = idx + AW'(1);
    wr_data = word;
    unique case (op)
      stqbf_pkg::OP_READ: begin
        rd_en = 1'b1;
      end
      stqbf_pkg::OP_INS_STEP: begin
        // shift the larger entry up one slot, or drop the new task in its gap
        rd_en   = 1'b1;
        rd_addr = idx - AW'(1);
        wr_en   = 1'b1;
        wr_data = status.greater ? rd_data : word;
      end
      stqbf_pkg::OP_PUT_FRONT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      stqbf_pkg::OP_EVAL_STEP: begin
        rd_en   = 1'b1;
        rd_addr = idx + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Walk registers and result payload
  always_ff @(posedge clk) begin
    unique case (op)
      stqbf_pkg::OP_LOAD: begin
        word      <= {task_priority, task_complexity, task_hours};
        idx       <= (action == stqbf_pkg::ACT_EVALUATE) ? '0 : AW'(count - CW'(1));
        sum       <= '0;
        fit       <= '0;
        full_flag <= (action == stqbf_pkg::ACT_INSERT) && status.count_full;
      end
      stqbf_pkg::OP_INS_STEP: begin
        if (status.greater) begin
          idx <= idx - AW'(1);
        end
      end
      stqbf_pkg::OP_EVAL_STEP: begin
        sum <= sum_next;
        if (!status.over) begin
          fit <= idx_inc;
          idx <= idx + AW'(1);
        end
      end
      stqbf_pkg::OP_RESULT: begin
        fit_count    <= stqbf_pkg::OUT_CNT_W'(fit);
        queue_full   <= full_flag;
        stored_count <= stqbf_pkg::OUT_CNT_W'(count);
      end
      default: begin
      end
    endcase
  end

  // Entry count and budget register
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      budget_hours <= '0;
    end else begin
      if (cfg_wr_en) begin
        budget_hours <= stqbf_pkg::BUD_W'(cfg_wr_data) *
                        stqbf_pkg::BUD_W'(stqbf_pkg::HOURS_PER_DAY);
      end
      if ((op == stqbf_pkg::OP_PUT_FRONT) ||
          ((op == stqbf_pkg::OP_INS_STEP) && !status.greater)) begin
        count <= count + CW'(1);
      end
    end
  end

endmodule

### hdl/stqbf_ctrl.sv
module stqbf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   action,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  stqbf_pkg::dp_status_t  status,
  output stqbf_pkg::dp_op_t      op
);

  stqbf_pkg::state_t state;
  stqbf_pkg::state_t state_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stqbf_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    op             = stqbf_pkg::OP_NONE;
    in_ready       = 1'b0;
    // drop the result once taken
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      stqbf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = stqbf_pkg::OP_LOAD;
          if (action == stqbf_pkg::ACT_EVALUATE) begin
            state_next = status.count_zero ? stqbf_pkg::S_FINISH : stqbf_pkg::S_EVAL_READ;
          end else if (status.count_full) begin
            state_next = stqbf_pkg::S_FINISH;
          end else if (status.count_zero) begin
            state_next = stqbf_pkg::S_PUT_FRONT;
          end else begin
            state_next = stqbf_pkg::S_INS_READ;
          end
        end
      end
      stqbf_pkg::S_INS_READ: begin
        op         = stqbf_pkg::OP_READ;
        state_next = stqbf_pkg::S_INS_STEP;
      end
      stqbf_pkg::S_INS_STEP: begin
        op = stqbf_pkg::OP_INS_STEP;
        if (!status.greater) begin
          state_next = stqbf_pkg::S_FINISH;
        end else if (status.idx_zero) begin
          state_next = stqbf_pkg::S_PUT_FRONT;
        end
      end
      stqbf_pkg::S_PUT_FRONT: begin
        op         = stqbf_pkg::OP_PUT_FRONT;
        state_next = stqbf_pkg::S_FINISH;
      end
      stqbf_pkg::S_EVAL_READ: begin
        op         = stqbf_pkg::OP_READ;
        state_next = stqbf_pkg::S_EVAL_STEP;
      end
      stqbf_pkg::S_EVAL_STEP: begin
        op = stqbf_pkg::OP_EVAL_STEP;
        if (status.over || status.last) begin
          state_next = stqbf_pkg::S_FINISH;
        end
      end
      stqbf_pkg::S_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          op             = stqbf_pkg::OP_RESULT;
          out_valid_next = 1'b1;
          state_next     = stqbf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = stqbf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hdl/sorted_task_queue_budget_fit_unit.sv
// Sorted task queue with budget fit.
// Input channel (in_valid/in_ready): one beat carries action plus the task
// fields. Action insert places the task in a list sorted by priority
// ascending, complexity descending, hours ascending, after any equal keys;
// a full list drops the task and reports queue_full. Action evaluate walks
// the list from the front and reports in fit_count the longest prefix whose
// summed hours stay within budget_days * 24.
// Output channel (out_valid/out_ready): exactly one beat per input beat,
// with stored_count giving the entries held afterwards.
// Configuration: cfg_wr_en with cfg_wr_data writes budget_days at once.
// Timing: the entry store is a memory with one write and one registered
// read port, so the walk advances one entry per cycle. An insert reads the
// last entry, shifts each larger one up a slot and puts the task in the gap
// or at the front; an evaluate reads from the front until the budget is
// passed or the list ends. An empty list or an insert into a full one skips
// the walk. One item is in work at a time: the next beat can be taken in the
// cycle after the result enters the output register, even while it waits.
// Reset (rst, synchronous) empties the list and clears the budget; the store
// itself needs no clearing pass. A stalled receiver holds the result and,
// once the next item is finished, holds the block until the beat is taken.
module sorted_task_queue_budget_fit_unit #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [stqbf_pkg::PRI_W-1:0]       task_priority,
  input  logic [stqbf_pkg::CPX_W-1:0]       task_complexity,
  input  logic [stqbf_pkg::HRS_W-1:0]       task_hours,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [stqbf_pkg::OUT_CNT_W-1:0]   fit_count,
  output logic                              queue_full,
  output logic [stqbf_pkg::OUT_CNT_W-1:0]   stored_count,
  input  logic                              cfg_wr_en,
  input  logic [stqbf_pkg::DAYS_W-1:0]      cfg_wr_data
);

  stqbf_pkg::dp_op_t     op;
  stqbf_pkg::dp_status_t status;

  // Sequencer: decides each cycle what the datapath does
  stqbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  // Store, walk index, running sum and result register
  stqbf_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .action          (action),
    .task_priority   (task_priority),
    .task_complexity (task_complexity),
    .task_hours      (task_hours),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .status          (status),
    .fit_count       (fit_count),
    .queue_full      (queue_full),
    .stored_count    (stored_count)
  );

endmodule

### bench/task_queue_board_pkg.sv
package task_queue_board_pkg;
  import stqbf_pkg::*;

  typedef struct packed {
    logic             action;
    logic [PRI_W-1:0] priority_f;
    logic [CPX_W-1:0] complexity_f;
    logic [HRS_W-1:0] hours_f;
  } task_beat_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] fit_count;
    logic                 queue_full;
    logic [OUT_CNT_W-1:0] stored_count;
  } fit_result_t;

  // Tracks the sorted task list and the budget, and checks result beats in order.
  class task_queue_board #(int unsigned DEPTH = 64);
    task_word_t     sorted_tasks[DEPTH];
    int unsigned    held = 0;
    logic [DAYS_W-1:0] budget_days = '0;
    fit_result_t    expected_results[$];
    int unsigned    failures = 0;

    // Smaller key sorts first: priority up, complexity down, hours up.
    static function logic [WORD_W-1:0] order_key(task_word_t w);
      return {w[WORD_W-1 -: PRI_W], ~w[HRS_W +: CPX_W], w[HRS_W-1:0]};
    endfunction

    function longint unsigned prefix_hours(int unsigned k);
      longint unsigned acc;
      acc = 0;
      for (int unsigned i = 0; i < k && i < held; i++)
        acc += sorted_tasks[i][HRS_W-1:0];
      return acc;
    endfunction

    function void note_task_beat(task_beat_t b);
      fit_result_t     r;
      task_word_t      w;
      int unsigned     pos;
      longint unsigned limit_hours;
      longint unsigned acc;
      r = '0;
      if (b.action == ACT_INSERT) begin
        if (held >= DEPTH) begin
          r.queue_full = 1'b1;
        end else begin
          w = {b.priority_f, b.complexity_f, b.hours_f};
          pos = 0;
          // Walk past every equal key so arrival order holds on ties.
          while (pos < held && order_key(sorted_tasks[pos]) <= order_key(w))
            pos++;
          for (int unsigned i = held; i > pos; i--)
            sorted_tasks[i] = sorted_tasks[i-1];
          sorted_tasks[pos] = w;
          held++;
        end
      end else begin
        limit_hours = 64'(budget_days) * HOURS_PER_DAY;
        acc = 0;
        for (int unsigned i = 0; i < held; i++) begin
          acc += sorted_tasks[i][HRS_W-1:0];
          if (acc > limit_hours)
            break;
          r.fit_count = r.fit_count + 1'b1;
        end
      end
      r.stored_count = OUT_CNT_W'(held);
      expected_results.push_back(r);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10)
        $display("[%0t] %s", $realtime, msg);
    endfunction

    function void check_result_beat(fit_result_t got);
      fit_result_t want;
      if (expected_results.size() == 0) begin
        flag($sformatf("result beat with nothing expected: fit %0d full %0d stored %0d",
                       got.fit_count, got.queue_full, got.stored_count));
        return;
      end
      want = expected_results.pop_front();
      if (got.fit_count !== want.fit_count)
        flag($sformatf("fit_count exp %0d got %0d", want.fit_count, got.fit_count));
      if (got.queue_full !== want.queue_full)
        flag($sformatf("queue_full exp %0d got %0d", want.queue_full, got.queue_full));
      if (got.stored_count !== want.stored_count)
        flag($sformatf("stored_count exp %0d got %0d", want.stored_count, got.stored_count));
    endfunction
  endclass

endpackage

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stqbf_pkg::*;
  import task_queue_board_pkg::*;

  localparam int unsigned QUEUE_DEPTH     = 64;
  localparam int unsigned NUM_PHASES      = 34;
  localparam int unsigned ITEMS_PER_PHASE = 24;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 100;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 action = ACT_INSERT;
  logic [PRI_W-1:0]     task_priority = '0;
  logic [CPX_W-1:0]     task_complexity = '0;
  logic [HRS_W-1:0]     task_hours = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_CNT_W-1:0] fit_count;
  logic                 queue_full;
  logic [OUT_CNT_W-1:0] stored_count;
  logic                 cfg_wr_en = 1'b0;
  logic [DAYS_W-1:0]    cfg_wr_data = '0;

  // Stimulus-owned knobs read by the receiver process.
  logic        allow_idle = 1'b1;
  logic        hold_request = 1'b0;
  int unsigned cycle_count = 0;

  task_queue_board #(QUEUE_DEPTH) board = new;

  sorted_task_queue_budget_fit_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .task_priority   (task_priority),
    .task_complexity (task_complexity),
    .task_hours      (task_hours),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .fit_count       (fit_count),
    .queue_full      (queue_full),
    .stored_count    (stored_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Monitor: note every accepted task beat, check every accepted result beat.
  // Sample at the edge, so values are those set up before it.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        board.note_task_beat({action, task_priority, task_complexity, task_hours});
      if (out_valid && out_ready)
        board.check_result_beat({fit_count, queue_full, stored_count});
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // block fills its output register and stalls its input.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= allow_idle ? ($urandom_range(99) >= 36) : 1'b1;
    end
  end

  // Offer one beat, with a random gap first when allow_idle is set; return at the accepting edge.
  task automatic send_beat(task_beat_t b);
    if (allow_idle) begin
      while ($urandom_range(99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    action          <= b.action;
    task_priority   <= b.priority_f;
    task_complexity <= b.complexity_f;
    task_hours      <= b.hours_f;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_task(logic act, int unsigned pri, int unsigned cpx, int unsigned hrs);
    task_beat_t b;
    b.action       = act;
    b.priority_f   = PRI_W'(pri);
    b.complexity_f = CPX_W'(cpx);
    b.hours_f      = HRS_W'(hrs);
    send_beat(b);
  endtask

  // Drop valid and hold until every expected result beat has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_results.size() != 0);
  endtask

  // Write the budget while the block is idle.
  task automatic write_budget(logic [DAYS_W-1:0] days);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= days;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.budget_days = days;
  endtask

  // Skew small values so ties on priority and complexity are common.
  function automatic logic [7:0] pick_key_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return 8'($urandom_range(3));
    if (roll < 58) return 8'h00;
    if (roll < 66) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [HRS_W-1:0] pick_hours();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 50) return HRS_W'($urandom_range(60));
    if (roll < 70) return HRS_W'($urandom_range(2000));
    return HRS_W'($urandom_range(65535));
  endfunction

  // Insert-heavy until the list is full, then mostly evaluate.
  function automatic task_beat_t pick_beat();
    task_beat_t  b;
    int unsigned insert_pct;
    insert_pct = (board.held < QUEUE_DEPTH) ? 55 : 25;
    b.action       = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_EVALUATE;
    b.priority_f   = pick_key_byte();
    b.complexity_f = pick_key_byte();
    b.hours_f      = pick_hours();
    return b;
  endfunction

  // Extremes, random, and budgets set just around a prefix sum of the list so
  // the fit count lands anywhere along it.
  function automatic logic [DAYS_W-1:0] pick_budget(int unsigned phase);
    longint unsigned days;
    case (phase % 6)
      0: return '0;
      1: return '1;
      2: return DAYS_W'($urandom_range(65535));
      default: begin
        days = board.prefix_hours($urandom_range(board.held)) / HOURS_PER_DAY
               + $urandom_range(1);
        return (days > 65535) ? '1 : DAYS_W'(days);
      end
    endcase
  endfunction

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty evaluate, extreme keys, equal keys, zero-hour tasks.
    send_task(ACT_EVALUATE, 255, 255, 65535);
    send_task(ACT_INSERT,     0,   0,     0);
    send_task(ACT_INSERT,   255, 255, 65535);
    send_task(ACT_INSERT,     0, 255,     0);
    send_task(ACT_INSERT,     0, 255,     0);
    send_task(ACT_INSERT,   255,   0, 65535);
    send_task(ACT_INSERT,   128, 128,     1);
    send_task(ACT_INSERT,   128, 128,     0);
    send_task(ACT_EVALUATE,   0,   0,     0);
    drain_results();
    write_budget('1);
    send_task(ACT_EVALUATE, 0, 0, 0);
    drain_results();
    write_budget(DAYS_W'(1));
    send_task(ACT_EVALUATE, 0, 0, 0);
    send_task(ACT_INSERT, 1, 1, 24);
    send_task(ACT_EVALUATE, 0, 0, 0);

    // Random phases; each starts idle with a fresh budget.
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      allow_idle   <= !(phase >= 10 && phase < 16);
      hold_request <= (phase == 20);
      write_budget(pick_budget(phase));
      repeat (ITEMS_PER_PHASE) send_beat(pick_beat());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.expected_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
